@@ sv/sakc_pkg.sv @@
// Package: shared parameters and codes for the set-associative key-value cache.
`default_nettype none
package sakc_pkg;
    localparam int DEF_MAX_SETS  = 16;
    localparam int DEF_MAX_WAYS  = 8;
    localparam int DEF_KEY_BYTES = 8;

    localparam int FUNC_W   = 2;
    localparam int KEY_W    = 64;
    localparam int VAL_W    = 64;
    localparam int STATUS_W = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;
    localparam int SETS_CFG_W = 5;
    localparam int WAYS_CFG_W = 4;

    localparam logic [FUNC_W-1:0] FUNC_PUT    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_GET    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_UPDATED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_GET_HIT   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_GET_MISS  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_SETS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS = 1'd1;
endpackage
`default_nettype wire

@@ sv/sakc_if.sv @@
// Interfaces: request, result and configuration channels.
`default_nettype none
interface sakc_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [63:0] key;
    logic [63:0] value;
    modport source (output valid, func, key, value, input ready);
    modport sink   (input valid, func, key, value, output ready);
endinterface

interface sakc_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [63:0] read_value;
    modport source (output valid, status, read_value, input ready);
    modport sink   (input valid, status, read_value, output ready);
endinterface

interface sakc_cfg_if;
    logic       valid;
    logic       ready;
    logic [0:0] index;
    logic [4:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ sv/sakc_hash.sv @@
// Set index: byte sum of the key reduced modulo the sets in use, one subtract a cycle.
`default_nettype none
module sakc_hash #(
    parameter int MAX_SETS  = 16,
    parameter int KEY_BYTES = 8,
    parameter int SET_W     = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [sakc_pkg::KEY_W-1:0]  i_key,
    input  wire logic [8:0]                  i_num_sets,
    output logic                             o_done,
    output logic [SET_W-1:0]                 o_set
);
    import sakc_pkg::*;
    localparam int SUM_W = 11;

    logic [SUM_W-1:0] r_rem, n_rem;
    logic             r_busy, n_busy;
    logic [SUM_W-1:0] w_sum;
    logic [SUM_W-1:0] w_div;

    always_comb begin
        w_sum = '0;
        for (int b = 0; b < KEY_BYTES; b++) begin
            w_sum = w_sum + SUM_W'(i_key[8*b +: 8]);
        end
    end
    assign w_div = SUM_W'(i_num_sets);

    always_comb begin
        n_rem  = r_rem;
        n_busy = r_busy;
        o_done = 1'b0;
        if (i_start) begin
            n_rem  = w_sum;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (r_rem >= w_div) begin
                n_rem = r_rem - w_div;
            end else begin
                o_done = 1'b1;
                n_busy = 1'b0;
            end
        end
    end
    assign o_set = r_rem[SET_W-1:0];

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
    end
endmodule
`default_nettype wire

@@ sv/set_assoc_kv_cache_clock_top.sv @@
// Top level: set-associative key-value cache with second-chance clock replacement.
//   channel   dir  payload
//   req       in   func, key, value
//   rsp       out  status, read_value
//   cfg       in   index, data (sets_in_use, ways_in_use)
// One request at a time. The set is reduced from the key's byte sum by repeated subtraction after
// the accept, then the ways in use are searched in turn (read, compare), then on a put miss the
// hand walks the set for a way whose mark is clear.
// Reset clears valid bits, marks and hands in flip-flops at once; no clearing pass.
// A result waits in the output register; the next request is taken the cycle after it leaves.
`default_nettype none
module set_assoc_kv_cache_clock_top #(
    parameter int MAX_SETS  = sakc_pkg::DEF_MAX_SETS,
    parameter int MAX_WAYS  = sakc_pkg::DEF_MAX_WAYS,
    parameter int KEY_BYTES = sakc_pkg::DEF_KEY_BYTES
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    sakc_req_if.sink   req,
    sakc_rsp_if.source rsp,
    sakc_cfg_if.sink   cfg
);
    import sakc_pkg::*;
    localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int ENT   = MAX_SETS * MAX_WAYS;
    localparam int ENT_W = SET_W + WAY_W;
    localparam logic [KEY_W-1:0] KMASK =
        (KEY_BYTES >= 8) ? '1 : KEY_W'((65'd1 << (8 * KEY_BYTES)) - 65'd1);

    localparam logic [2:0] S_IDLE = 3'd0, S_HASH = 3'd1, S_SRCH = 3'd2,
                           S_CMP = 3'd3, S_WALK = 3'd4, S_OUT = 3'd5;

    logic [SETS_CFG_W-1:0] r_sets;
    logic [WAYS_CFG_W-1:0] r_ways;
    logic [8:0]            w_nsets;
    logic [6:0]            w_nways;

    // key and value memories, one read port each
    logic [KEY_W-1:0] r_kmem [ENT];
    logic [VAL_W-1:0] r_vmem [ENT];
    logic [KEY_W-1:0] r_krd;
    logic [VAL_W-1:0] r_vrd;
    logic [ENT-1:0]   r_valid, r_mark;
    logic [WAY_W-1:0] r_hand [MAX_SETS];

    logic [2:0]        r_state;
    logic [FUNC_W-1:0] r_func;
    logic [KEY_W-1:0]  r_key;
    logic [VAL_W-1:0]  r_val;
    logic [SET_W-1:0]  r_set;
    logic [WAY_W-1:0]  r_way;
    logic [STATUS_W-1:0] r_status;
    logic [VAL_W-1:0]  r_rdv;

    logic             w_hdone;
    logic [SET_W-1:0] w_hset;
    logic [ENT_W-1:0] w_raddr;
    logic [ENT_W-1:0] w_e;
    logic [WAY_W-1:0] w_hw;
    logic             w_last;
    logic [ENT-1:0]   w_clr;

    assign w_nsets = (r_sets == '0) ? 9'd1 :
                     (32'(r_sets) > MAX_SETS) ? 9'(MAX_SETS) : 9'(r_sets);
    assign w_nways = (r_ways == '0) ? 7'd1 :
                     (32'(r_ways) > MAX_WAYS) ? 7'(MAX_WAYS) : 7'(r_ways);

    sakc_hash #(.MAX_SETS(MAX_SETS), .KEY_BYTES(KEY_BYTES), .SET_W(SET_W)) u_hash (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_start(req.valid && req.ready),
        .i_key(req.key & KMASK),
        .i_num_sets(w_nsets),
        .o_done(w_hdone), .o_set(w_hset)
    );

    assign req.ready      = (r_state == S_IDLE);
    assign cfg.ready      = 1'b1;
    assign rsp.valid      = (r_state == S_OUT);
    assign rsp.status     = r_status;
    assign rsp.read_value = r_rdv;

    function automatic logic [ENT_W-1:0] ent(input logic [SET_W-1:0] s,
                                             input logic [WAY_W-1:0] w);
        ent = ENT_W'(32'(s) * MAX_WAYS + 32'(w));
    endfunction

    // hand clamped to ways in use
    assign w_hw   = (7'(r_hand[r_set]) >= w_nways) ? '0 : r_hand[r_set];
    assign w_e    = ent(r_set, (r_state == S_WALK) ? w_hw : r_way);
    assign w_last = (7'(r_way) + 7'd1 >= w_nways);
    assign w_raddr = ent(r_set, r_way);

    // marks of the current set's ways in use, cleared when the hand wraps
    always_comb begin
        w_clr = '0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (7'(w) < w_nways) w_clr[ent(r_set, WAY_W'(w))] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_krd <= r_kmem[w_raddr];
        r_vrd <= r_vmem[w_raddr];
        if (r_state == S_WALK && !r_mark[w_e]) begin
            r_kmem[w_e] <= r_key;
            r_vmem[w_e] <= r_val;
        end else if (r_state == S_CMP && r_valid[w_raddr] && r_krd == r_key
                     && r_func == FUNC_PUT) begin
            r_vmem[w_raddr] <= r_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sets  <= 5'd16;
            r_ways  <= 4'd8;
            r_valid <= '0;
            r_mark  <= '0;
            for (int s = 0; s < MAX_SETS; s++) r_hand[s] <= '0;
        end else begin
            if (cfg.valid) begin
                unique case (cfg.index)
                    CFG_SETS: r_sets <= cfg.data;
                    CFG_WAYS: r_ways <= cfg.data[WAYS_CFG_W-1:0];
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (req.valid) begin
                        r_func  <= req.func;
                        r_key   <= req.key & KMASK;
                        r_val   <= req.value;
                        r_state <= S_HASH;
                    end
                end
                S_HASH: begin
                    if (w_hdone) begin
                        r_set   <= w_hset;
                        r_way   <= '0;
                        r_state <= S_SRCH;
                    end
                end
                S_SRCH: r_state <= S_CMP; // memory read in flight
                S_CMP: begin
                    r_rdv <= (r_valid[w_raddr] && r_krd == r_key && r_func == FUNC_GET) ?
                             r_vrd : '0;
                    if (r_valid[w_raddr] && r_krd == r_key) begin
                        r_state <= S_OUT;
                        case (r_func)
                            FUNC_PUT: begin
                                r_mark[w_raddr] <= 1'b1;
                                r_status <= ST_UPDATED;
                            end
                            FUNC_GET: begin
                                r_mark[w_raddr] <= 1'b1;
                                r_status <= ST_GET_HIT;
                            end
                            FUNC_REMOVE: begin
                                r_valid[w_raddr] <= 1'b0;
                                r_status <= ST_REMOVED;
                            end
                            default: r_status <= ST_GET_MISS;
                        endcase
                    end else if (!w_last) begin
                        r_way   <= r_way + 1'b1;
                        r_state <= S_SRCH;
                    end else begin
                        case (r_func)
                            FUNC_PUT: begin
                                r_status <= ST_INSERTED;
                                r_state  <= S_WALK;
                            end
                            FUNC_REMOVE: begin
                                r_status <= ST_NOT_FOUND;
                                r_state  <= S_OUT;
                            end
                            default: begin
                                r_status <= ST_GET_MISS;
                                r_state  <= S_OUT;
                            end
                        endcase
                    end
                end
                S_WALK: begin
                    if (!r_mark[w_e]) begin
                        r_valid[w_e] <= 1'b1;
                        r_state <= S_OUT;
                    end
                    if (7'(w_hw) + 7'd1 >= w_nways) begin
                        r_hand[r_set] <= '0;
                        r_mark <= r_mark & ~w_clr;
                    end else begin
                        r_hand[r_set] <= w_hw + 1'b1;
                        r_mark[w_e] <= 1'b0;
                    end
                end
                S_OUT: if (rsp.ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
